@@ rtl/awu_pkg.sv @@
// Shared constants, types and the sample scaling function of the word interleaver.
`timescale 1ns / 1ps
`default_nettype none

package awu_pkg;

    localparam int STREAMS_DEF  = 4;
    localparam int NUM_SAMPLES  = 8;
    localparam int SAMPLE_W     = 24;
    localparam int PROD_W       = SAMPLE_W + 17;
    localparam int FRAME_BYTES  = 6;
    localparam int OUT_BYTES    = 4;
    localparam int IN_DATA_W    = NUM_SAMPLES * SAMPLE_W;
    localparam int OUT_DATA_W   = 40;
    localparam int ADDR_W       = 4;

    localparam logic [15:0] GAIN_RESET    = 16'd16384;
    localparam logic [10:0] XFER_RESET    = 11'd88;
    localparam logic [10:0] XFER_MAX      = 11'd1024;
    localparam logic [1:0]  CHECK_SLOT    = 2'd2;

    typedef enum logic [1:0] {
        REG_GAIN  = 2'd0,
        REG_ORDER = 2'd1,
        REG_START = 2'd2,
        REG_XFER  = 2'd3
    } reg_idx_t;

    // Per-word control decided at acceptance
    typedef struct packed {
        logic       load;
        logic       fv;
        logic [2:0] sel;
        logic       check;
        logic       par;
        logic       endw;
    } word_ctl_t;

    typedef struct packed {
        logic [15:0] gain;
        logic        order;
    } cfg_t;

    // Round half up to 31 fraction bits, saturate to 32 bits, keep the top 24.
    function automatic logic [SAMPLE_W-1:0] scale_prod(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0]   q;
        logic signed [PROD_W-6:0] r;
        q = $signed({p[PROD_W-1], p}) + $signed((PROD_W+1)'(32));
        r = q[PROD_W:6];
        if (r > $signed((PROD_W-5)'(33'h07fffffff)))
            scale_prod = 24'h7fffff;
        else if (r < -$signed((PROD_W-5)'(33'h080000000)))
            scale_prod = 24'h800000;
        else
            scale_prod = r[31:8];
    endfunction

endpackage

`default_nettype wire

@@ rtl/awu_ctrl.sv @@
// Configuration registers and the word sequencer (position, cursor, load decision).
`timescale 1ns / 1ps
`default_nettype none

module awu_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [awu_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    input  wire logic                      acc,
    input  wire logic                      frame_valid,
    output awu_pkg::word_ctl_t             ctl,
    output awu_pkg::cfg_t                  cfg
);

    logic [15:0] gain_reg;
    logic        order_reg;
    logic [2:0]  start_reg;
    logic [10:0] xfer_reg;
    logic [2:0]  cursor_reg, cursor_next;
    logic        loaded_reg;
    logic [9:0]  wpos_reg, wpos_next;
    logic [10:0] len;
    logic [10:0] wpos_inc;
    logic        wr;
    awu_pkg::reg_idx_t idx;

    assign wr  = psel & penable & pwrite;
    assign idx = awu_pkg::reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        unique case (idx)
            awu_pkg::REG_GAIN:  prdata = {16'd0, gain_reg};
            awu_pkg::REG_ORDER: prdata = {31'd0, order_reg};
            awu_pkg::REG_START: prdata = {29'd0, start_reg};
            awu_pkg::REG_XFER:  prdata = {21'd0, xfer_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // Clamp length into 1..1024
    always_comb
    begin
        priority if (xfer_reg == 11'd0)
            len = 11'd1;
        else if (xfer_reg > awu_pkg::XFER_MAX)
            len = awu_pkg::XFER_MAX;
        else
            len = xfer_reg;
    end

    assign wpos_inc = {1'b0, wpos_reg} + 11'd1;

    always_comb
    begin
        ctl.check = (wpos_reg[1:0] == awu_pkg::CHECK_SLOT);
        ctl.par   = ~wpos_reg[2];
        ctl.load  = ~ctl.check & (~loaded_reg | (cursor_reg == 3'd0));
        ctl.fv    = frame_valid;
        ctl.sel   = cursor_reg;
        ctl.endw  = (wpos_inc >= len);
        wpos_next   = ctl.endw ? 10'd0 : wpos_inc[9:0];
        cursor_next = (cursor_reg >= 3'(awu_pkg::FRAME_BYTES - 1)) ? 3'd0 : cursor_reg + 3'd1;
    end

    assign cfg.gain  = gain_reg;
    assign cfg.order = order_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= awu_pkg::GAIN_RESET;
            order_reg  <= 1'b0;
            start_reg  <= 3'd0;
            xfer_reg   <= awu_pkg::XFER_RESET;
            cursor_reg <= 3'd0;
            loaded_reg <= 1'b0;
            wpos_reg   <= 10'd0;
        end
        else
        begin
            if (wr)
            begin
                unique case (idx)
                    awu_pkg::REG_GAIN:  gain_reg  <= pwdata[15:0];
                    awu_pkg::REG_ORDER: order_reg <= pwdata[0];
                    awu_pkg::REG_START:
                    begin
                        start_reg  <= pwdata[2:0];
                        cursor_reg <= (pwdata[2:0] < 3'(awu_pkg::FRAME_BYTES)) ?
                                      pwdata[2:0] : 3'd0;
                    end
                    awu_pkg::REG_XFER:  xfer_reg  <= pwdata[10:0];
                    default:            ;
                endcase
            end
            if (acc)
            begin
                wpos_reg <= wpos_next;
                if (!ctl.check)
                begin
                    loaded_reg <= 1'b1;
                    cursor_reg <= cursor_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/awu_lane.sv @@
// One stream lane: register samples, multiply by gain, scale and hold the 6-byte frame.
`timescale 1ns / 1ps
`default_nettype none

module awu_lane (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en1,
    input  wire logic                               en2,
    input  wire logic                               en3,
    input  wire logic signed [awu_pkg::SAMPLE_W-1:0] smp_l,
    input  wire logic signed [awu_pkg::SAMPLE_W-1:0] smp_r,
    input  awu_pkg::cfg_t                           cfg,
    input  awu_pkg::word_ctl_t                      ctl,
    output logic [7:0]                              lane_byte
);

    logic signed [awu_pkg::SAMPLE_W-1:0] l1_reg, r1_reg;
    logic signed [awu_pkg::PROD_W-1:0]   pl_reg, pr_reg;
    logic [7:0] frame_reg [awu_pkg::FRAME_BYTES];
    logic [7:0] frame_next [awu_pkg::FRAME_BYTES];
    logic [awu_pkg::SAMPLE_W-1:0] sl, sr;
    logic [7:0] cur [awu_pkg::FRAME_BYTES];

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            l1_reg <= smp_l;
            r1_reg <= smp_r;
        end
        if (en2)
        begin
            pl_reg <= l1_reg * $signed({1'b0, cfg.gain});
            pr_reg <= r1_reg * $signed({1'b0, cfg.gain});
        end
    end

    always_comb
    begin
        sl = awu_pkg::scale_prod(pl_reg);
        sr = awu_pkg::scale_prod(pr_reg);
        if (!ctl.fv)
        begin
            for (int i = 0; i < awu_pkg::FRAME_BYTES; i++)
                frame_next[i] = 8'd0;
        end
        else if (cfg.order)
        begin
            frame_next[0] = sl[7:0];  frame_next[1] = sl[15:8];  frame_next[2] = sl[23:16];
            frame_next[3] = sr[7:0];  frame_next[4] = sr[15:8];  frame_next[5] = sr[23:16];
        end
        else
        begin
            frame_next[0] = sl[23:16]; frame_next[1] = sl[15:8]; frame_next[2] = sl[7:0];
            frame_next[3] = sr[23:16]; frame_next[4] = sr[15:8]; frame_next[5] = sr[7:0];
        end
        // Bypass the fresh frame on a load word
        for (int i = 0; i < awu_pkg::FRAME_BYTES; i++)
            cur[i] = ctl.load ? frame_next[i] : frame_reg[i];
        unique case (ctl.sel)
            3'd0:    lane_byte = cur[0];
            3'd1:    lane_byte = cur[1];
            3'd2:    lane_byte = cur[2];
            3'd3:    lane_byte = cur[3];
            3'd4:    lane_byte = cur[4];
            3'd5:    lane_byte = cur[5];
            default: lane_byte = cur[0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < awu_pkg::FRAME_BYTES; i++)
                frame_reg[i] <= 8'd0;
        end
        else if (en3 && ctl.load)
        begin
            for (int i = 0; i < awu_pkg::FRAME_BYTES; i++)
                frame_reg[i] <= frame_next[i];
        end
    end

endmodule

`default_nettype wire

@@ rtl/audio_usb_word_interleaver_unit.sv @@
// Top level of the audio word interleaver: sequencer, stream lanes and output merge.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | tdata: sample_0..sample_7; tuser: frame_valid
//  m_*      | out | m_tvalid/m_tready  | tdata: stream0..3_byte, frame_taken;
//           |     |                    | tuser: is_check_word; tlast: transfer_end
//  apb      | in  | psel/penable       | gain, byte order, start byte, transfer words
//
// One word per cycle sustained while m_tready stays high; each accepted word passes the
// sample register, gain multiplier register and output register in that order.
// Each stage advances whenever the stage after it is empty or moving, so a stalled
// output still lets beats fill the empty stages behind it.
// Reset (rst_n, async low) clears stage valids, position, cursor and registers.
// Frame, cursor and position decisions are made at acceptance; the stored frame is
// written when its word enters the output register.
`timescale 1ns / 1ps
`default_nettype none

module audio_usb_word_interleaver_unit #(
    parameter int STREAMS = awu_pkg::STREAMS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // sample_0 [23:0] .. sample_7 [191:168]
    input  wire logic [awu_pkg::IN_DATA_W-1:0] s_tdata,
    // frame_valid
    input  wire logic                         s_tuser,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // stream0_byte [7:0] .. stream3_byte [31:24], frame_taken [32], zeros above
    output logic [awu_pkg::OUT_DATA_W-1:0]    m_tdata,
    // is_check_word
    output logic                              m_tuser,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [awu_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    logic acc, mv1, mv2, rdy2, rdy3;
    logic v1_reg, v2_reg, ov_reg;
    awu_pkg::word_ctl_t ctl_now, ctl1_reg, ctl2_reg;
    awu_pkg::cfg_t      cfg;
    logic [7:0] lane_bytes [STREAMS];
    logic [awu_pkg::OUT_DATA_W-1:0] odata_reg, odata_next;
    logic ouser_reg, olast_reg;

    assign pready = 1'b1;

    // Per-stage handshake: advance when the next stage is empty or moving
    assign rdy3     = ~ov_reg | m_tready;
    assign rdy2     = ~v2_reg | rdy3;
    assign s_tready = ~v1_reg | rdy2;
    assign acc      = s_tvalid & s_tready;
    assign mv1      = v1_reg & rdy2;
    assign mv2      = v2_reg & rdy3;

    awu_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .acc         (acc),
        .frame_valid (s_tuser),
        .ctl         (ctl_now),
        .cfg         (cfg)
    );

    // One lane per stream; streams past the sample list get silence
    for (genvar s = 0; s < STREAMS; s++)
    begin : g_lane
        logic signed [awu_pkg::SAMPLE_W-1:0] l_in, r_in;
        if (2 * s + 1 < awu_pkg::NUM_SAMPLES)
        begin : g_map
            assign l_in = s_tdata[(2*s)*awu_pkg::SAMPLE_W +: awu_pkg::SAMPLE_W];
            assign r_in = s_tdata[(2*s+1)*awu_pkg::SAMPLE_W +: awu_pkg::SAMPLE_W];
        end
        else
        begin : g_zero
            assign l_in = '0;
            assign r_in = '0;
        end
        awu_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .en1       (acc),
            .en2       (mv1),
            .en3       (mv2),
            .smp_l     (l_in),
            .smp_r     (r_in),
            .cfg       (cfg),
            .ctl       (ctl2_reg),
            .lane_byte (lane_bytes[s])
        );
    end

    // Merge lanes: check words override with stream number and inverted group parity
    always_comb
    begin
        odata_next = '0;
        for (int s = 0; s < awu_pkg::OUT_BYTES; s++)
        begin
            if (s < STREAMS)
                odata_next[8*s +: 8] = ctl2_reg.check ?
                                       (8'(2 * s) | {7'd0, ctl2_reg.par}) : lane_bytes[s];
        end
        odata_next[8*awu_pkg::OUT_BYTES] = ctl2_reg.load & ctl2_reg.fv;
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            ctl1_reg <= ctl_now;
        if (mv1)
            ctl2_reg <= ctl1_reg;
        if (mv2)
        begin
            odata_reg <= odata_next;
            ouser_reg <= ctl2_reg.check;
            olast_reg <= ctl2_reg.endw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                v1_reg <= acc;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                ov_reg <= v2_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = ouser_reg;
    assign m_tlast  = olast_reg;

endmodule

`default_nettype wire

@@ rtl/awu_checker.sv @@
// Port-level checker for the word interleaver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module awu_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic                          m_tuser,
    input wire logic [awu_pkg::OUT_DATA_W-1:0] m_tdata
);

    // Stalled output beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // Check words never consume a frame
    a_check_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tdata[8*awu_pkg::OUT_BYTES])
        else $error("check word marked frame taken");

    // Check bytes of streams 0 and 1 carry the stream number and a shared parity
    a_check_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[7:1] == 7'd0 && m_tdata[15:9] == 7'd1
                                && m_tdata[0] == m_tdata[8])
        else $error("malformed check bytes");

    // An empty output means the pipe can take a beat
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind audio_usb_word_interleaver_unit awu_checker u_awu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);

`default_nettype wire
